// File: rtl/bidi_pkg.sv
package bidi_pkg;

  localparam int LVL_W = 7;
  localparam int CLS_W = 5;
  localparam int OVR_W = 2;

  localparam logic [CLS_W-1:0] CL_L   = 5'd0;
  localparam logic [CLS_W-1:0] CL_R   = 5'd1;
  localparam logic [CLS_W-1:0] CL_BN  = 5'd9;
  localparam logic [CLS_W-1:0] CL_B   = 5'd10;
  localparam logic [CLS_W-1:0] CL_LRE = 5'd14;
  localparam logic [CLS_W-1:0] CL_LRO = 5'd15;
  localparam logic [CLS_W-1:0] CL_RLE = 5'd16;
  localparam logic [CLS_W-1:0] CL_RLO = 5'd17;
  localparam logic [CLS_W-1:0] CL_PDF = 5'd18;
  localparam logic [CLS_W-1:0] CL_LRI = 5'd19;
  localparam logic [CLS_W-1:0] CL_RLI = 5'd20;
  localparam logic [CLS_W-1:0] CL_FSI = 5'd21;
  localparam logic [CLS_W-1:0] CL_PDI = 5'd22;

  typedef enum logic [OVR_W-1:0] {
    OVR_NONE = 2'd0,
    OVR_LTR  = 2'd1,
    OVR_RTL  = 2'd2
  } ovr_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_t;

  function automatic logic [CLS_W-1:0] apply_ovr(input ovr_t ovr, input logic [CLS_W-1:0] cls);
    logic [CLS_W-1:0] res;
    unique case (ovr)
      OVR_LTR: res = CL_L;
      OVR_RTL: res = CL_R;
      default: res = cls;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/bidi_ram.sv
module bidi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/bidi_explicit_level_resolver.sv
// Explicit embedding level resolver for bidirectional text (rules X1 to X8).
// Each input item carries one character's bidi class; each gives exactly one
// result item with its explicit level, a flag that is low for items removed by
// X9 (embeddings, overrides, PDF, BN), and its class after any override, with
// FSI turned into LRI or RLI. The directional status stack sits in a RAM with
// a registered read; the top entry, the index of the topmost isolate entry,
// the depth and the overflow counters sit in flip-flops. A PDF or PDI that
// pops to an entry above the paragraph entry waits in the pop state for the
// read of the new top from the stack RAM before its result is loaded. An
// input buffer and an output register let the next item be taken while a
// result waits. base_level may be written only while the block is idle; a
// text_start item clears the stack and counters before it is handled.
module bidi_explicit_level_resolver
  import bidi_pkg::*;
#(
  parameter int STACK_ENTRIES   = 127,
  parameter int MAX_DEPTH_LEVEL = 125,
  parameter int COUNTER_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_class[4:0], fsi_is_rtl[5], text_start[6], zero[7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // embed_level[6:0], level_assigned[7], out_class[12:8], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data    // base_level
);

  localparam int IW = $clog2(STACK_ENTRIES);
  localparam int DW = $clog2(STACK_ENTRIES + 1);
  localparam int EW = LVL_W + OVR_W + IW;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX   = '1;
  localparam logic [DW-1:0]           DEPTH_TOP = DW'(STACK_ENTRIES);
  localparam logic [LVL_W:0]          LVL_LIMIT = (LVL_W + 1)'(MAX_DEPTH_LEVEL);

  state_t state_r, state_nxt;

  // input buffer
  logic             ib_valid_r;
  logic [CLS_W-1:0] ib_cls_r;
  logic             ib_fsi_r;
  logic             ib_start_r;

  // stack control state
  logic [DW-1:0]           depth_r, depth_nxt;
  logic [IW-1:0]           last_iso_r, last_iso_nxt;
  logic [IW-1:0]           open_iso_r, open_iso_nxt;
  logic [COUNTER_BITS-1:0] iso_ovf_r, iso_ovf_nxt;
  logic [COUNTER_BITS-1:0] emb_ovf_r, emb_ovf_nxt;
  logic [LVL_W-1:0]        top_level_r, top_level_nxt;
  ovr_t                    top_ovr_r, top_ovr_nxt;
  logic                    base_r;
  logic                    pend_pdi_r, pend_pdi_nxt;

  // output register
  logic             out_valid_r;
  logic [LVL_W-1:0] out_level_r;
  logic             out_asg_r;
  logic [CLS_W-1:0] out_cls_r;

  // stack RAM
  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic             go, out_free, need_read;
  logic             res_load, res_asg;
  logic [LVL_W-1:0] res_level;
  logic [CLS_W-1:0] res_cls;

  // effective state after an optional text_start clear
  logic [DW-1:0]           depth_eff, depth_m1;
  logic [IW-1:0]           last_iso_eff, open_eff, top_idx;
  logic [COUNTER_BITS-1:0] iso_eff, emb_eff;
  logic                    at_base, top_iso, room, rtl;
  logic [LVL_W-1:0]        cur_level, base_level;
  ovr_t                    cur_ovr;
  logic [LVL_W:0]          lvl_odd, lvl_even, lvl;
  ovr_t                    push_ovr;
  ovr_t                    rd_ovr;
  logic [LVL_W-1:0]        rd_level;
  logic [IW-1:0]           rd_link;

  bidi_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_ENTRIES)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign go        = (state_r == S_IDLE) && ib_valid_r && out_free;
  assign in_tready = !ib_valid_r || go;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_cls_r, out_asg_r, out_level_r};

  assign base_level   = LVL_W'(base_r);
  assign depth_eff    = ib_start_r ? DW'(1) : depth_r;
  assign last_iso_eff = ib_start_r ? '0 : last_iso_r;
  assign open_eff     = ib_start_r ? '0 : open_iso_r;
  assign iso_eff      = ib_start_r ? '0 : iso_ovf_r;
  assign emb_eff      = ib_start_r ? '0 : emb_ovf_r;
  assign at_base      = depth_eff == DW'(1);
  assign cur_level    = at_base ? base_level : top_level_r;
  assign cur_ovr      = at_base ? OVR_NONE : top_ovr_r;
  assign depth_m1     = depth_eff - DW'(1);
  assign top_idx      = depth_m1[IW-1:0];
  assign top_iso      = !at_base && (last_iso_eff == top_idx);
  assign room         = (iso_eff == '0) && (emb_eff == '0) && (depth_eff < DEPTH_TOP);
  assign lvl_odd      = ({1'b0, cur_level} + (LVL_W + 1)'(1)) | (LVL_W + 1)'(1);
  assign lvl_even     = ({1'b0, cur_level} + (LVL_W + 1)'(2)) & ~(LVL_W + 1)'(1);
  assign rtl          = (ib_cls_r == CL_RLI) || (ib_cls_r == CL_RLE) ||
                        (ib_cls_r == CL_RLO) || ((ib_cls_r == CL_FSI) && ib_fsi_r);
  assign lvl          = rtl ? lvl_odd : lvl_even;
  assign push_ovr     = (ib_cls_r == CL_RLO) ? OVR_RTL :
                        (ib_cls_r == CL_LRO) ? OVR_LTR : OVR_NONE;

  assign rd_level = ram_rdata[LVL_W-1:0];
  assign rd_ovr   = ovr_t'(ram_rdata[LVL_W +: OVR_W]);
  assign rd_link  = ram_rdata[LVL_W+OVR_W +: IW];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (go && need_read) begin
        state_nxt = S_POP;
      end
      S_POP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack update and result
  always_comb begin
    depth_nxt     = depth_r;
    last_iso_nxt  = last_iso_r;
    open_iso_nxt  = open_iso_r;
    iso_ovf_nxt   = iso_ovf_r;
    emb_ovf_nxt   = emb_ovf_r;
    top_level_nxt = top_level_r;
    top_ovr_nxt   = top_ovr_r;
    pend_pdi_nxt  = pend_pdi_r;
    ram_we        = 1'b0;
    ram_waddr     = depth_eff[IW-1:0];
    ram_wdata     = {last_iso_eff, push_ovr, lvl[LVL_W-1:0]};
    ram_re        = 1'b0;
    ram_raddr     = '0;
    need_read     = 1'b0;
    res_load      = 1'b0;
    res_level     = '0;
    res_asg       = 1'b0;
    res_cls       = ib_cls_r;

    if (state_r == S_POP) begin
      top_level_nxt = rd_level;
      top_ovr_nxt   = rd_ovr;
      last_iso_nxt  = rd_link;
      res_load      = 1'b1;
      if (pend_pdi_r) begin
        res_level = rd_level;
        res_asg   = 1'b1;
        res_cls   = apply_ovr(rd_ovr, CL_PDI);
      end else begin
        res_cls = CL_PDF;
      end
    end else if (go) begin
      depth_nxt    = depth_eff;
      last_iso_nxt = last_iso_eff;
      open_iso_nxt = open_eff;
      iso_ovf_nxt  = iso_eff;
      emb_ovf_nxt  = emb_eff;
      res_load     = 1'b1;
      unique case (ib_cls_r)
        CL_RLE, CL_RLO, CL_LRE, CL_LRO: begin
          if (room && (lvl <= LVL_LIMIT)) begin
            ram_we        = 1'b1;
            top_level_nxt = lvl[LVL_W-1:0];
            top_ovr_nxt   = push_ovr;
            depth_nxt     = depth_eff + DW'(1);
          end else if ((iso_eff == '0) && (emb_eff != CNT_MAX)) begin
            emb_ovf_nxt = emb_eff + COUNTER_BITS'(1);
          end
        end
        CL_LRI, CL_RLI, CL_FSI: begin
          res_level = cur_level;
          res_asg   = 1'b1;
          if (cur_ovr != OVR_NONE) begin
            res_cls = apply_ovr(cur_ovr, ib_cls_r);
          end else if (ib_cls_r == CL_FSI) begin
            res_cls = rtl ? CL_RLI : CL_LRI;
          end
          if (room && (lvl <= LVL_LIMIT)) begin
            // an isolate entry links to itself as the topmost isolate
            ram_we        = 1'b1;
            ram_wdata     = {depth_eff[IW-1:0], OVR_NONE, lvl[LVL_W-1:0]};
            top_level_nxt = lvl[LVL_W-1:0];
            top_ovr_nxt   = OVR_NONE;
            last_iso_nxt  = depth_eff[IW-1:0];
            depth_nxt     = depth_eff + DW'(1);
            open_iso_nxt  = open_eff + IW'(1);
          end else if (iso_eff != CNT_MAX) begin
            iso_ovf_nxt = iso_eff + COUNTER_BITS'(1);
          end
        end
        CL_PDI: begin
          res_level = cur_level;
          res_asg   = 1'b1;
          res_cls   = apply_ovr(cur_ovr, CL_PDI);
          if (iso_eff != '0) begin
            iso_ovf_nxt = iso_eff - COUNTER_BITS'(1);
          end else if (open_eff != '0) begin
            // drop everything down to and including the topmost isolate
            emb_ovf_nxt  = '0;
            open_iso_nxt = open_eff - IW'(1);
            depth_nxt    = DW'(last_iso_eff);
            if (last_iso_eff == IW'(1)) begin
              last_iso_nxt = '0;
              res_level    = base_level;
              res_cls      = CL_PDI;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = last_iso_eff - IW'(1);
              need_read    = 1'b1;
              pend_pdi_nxt = 1'b1;
              res_load     = 1'b0;
            end
          end
        end
        CL_PDF: begin
          if (iso_eff == '0) begin
            if (emb_eff != '0) begin
              emb_ovf_nxt = emb_eff - COUNTER_BITS'(1);
            end else if (!at_base && !top_iso) begin
              depth_nxt = depth_m1;
              if (depth_eff != DW'(2)) begin
                ram_re       = 1'b1;
                ram_raddr    = top_idx - IW'(1);
                need_read    = 1'b1;
                pend_pdi_nxt = 1'b0;
                res_load     = 1'b0;
              end
            end
          end
        end
        CL_B: begin
          res_level    = base_level;
          res_asg      = 1'b1;
          depth_nxt    = DW'(1);
          last_iso_nxt = '0;
          open_iso_nxt = '0;
          iso_ovf_nxt  = '0;
          emb_ovf_nxt  = '0;
        end
        CL_BN: begin
          res_asg = 1'b0;
        end
        default: begin
          res_level = cur_level;
          res_asg   = 1'b1;
          res_cls   = apply_ovr(cur_ovr, ib_cls_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ib_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      depth_r     <= DW'(1);
      last_iso_r  <= '0;
      open_iso_r  <= '0;
      iso_ovf_r   <= '0;
      emb_ovf_r   <= '0;
      base_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      depth_r    <= depth_nxt;
      last_iso_r <= last_iso_nxt;
      open_iso_r <= open_iso_nxt;
      iso_ovf_r  <= iso_ovf_nxt;
      emb_ovf_r  <= emb_ovf_nxt;
      if (in_tvalid && in_tready) begin
        ib_valid_r <= 1'b1;
      end else if (go) begin
        ib_valid_r <= 1'b0;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    top_level_r <= top_level_nxt;
    top_ovr_r   <= top_ovr_nxt;
    pend_pdi_r  <= pend_pdi_nxt;
    if (in_tvalid && in_tready) begin
      ib_cls_r   <= in_tdata[4:0];
      ib_fsi_r   <= in_tdata[5];
      ib_start_r <= in_tdata[6];
    end
    if (res_load) begin
      out_level_r <= res_level;
      out_asg_r   <= res_asg;
      out_cls_r   <= res_cls;
    end
  end

endmodule

// File: test/tb_top.sv
module tb_top;
  import bidi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_SLOTS = 127;
  localparam int DEEPEST     = 125;
  localparam int CNT_MAX     = 65535;
  localparam int LIMIT       = 100000;
  localparam int PRESSURE_AT = 350;

  typedef struct {
    logic [LVL_W-1:0] level;
    logic             assigned;
    logic [CLS_W-1:0] cls;
  } level_result_t;

  class level_scoreboard;
    bit               base;
    bit [LVL_W-1:0]   lvl_q [STACK_SLOTS];
    ovr_t             ovr_q [STACK_SLOTS];
    bit               iso_q [STACK_SLOTS];
    int unsigned      depth;
    int unsigned      iso_ovf;
    int unsigned      emb_ovf;
    int unsigned      open_iso;
    level_result_t    due_results[$];
    int               errors;

    function new();
      base = 1'b0;
      foreach (lvl_q[i]) begin
        lvl_q[i] = '0;
        ovr_q[i] = OVR_NONE;
        iso_q[i] = 1'b0;
      end
      errors = 0;
      restart();
    endfunction

    function void restart();
      lvl_q[0] = LVL_W'(base);
      ovr_q[0] = OVR_NONE;
      iso_q[0] = 1'b0;
      depth = 1;
      iso_ovf = 0;
      emb_ovf = 0;
      open_iso = 0;
    endfunction

    function void load_base(bit b);
      base = b;
      lvl_q[0] = LVL_W'(b);
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function bit may_push(int unsigned lvl);
      return lvl <= DEEPEST && iso_ovf == 0 && emb_ovf == 0 && depth < STACK_SLOTS;
    endfunction

    function void push(int unsigned lvl, ovr_t o, bit iso);
      lvl_q[depth] = lvl[LVL_W-1:0];
      ovr_q[depth] = o;
      iso_q[depth] = iso;
      depth++;
    endfunction

    function void open_embedding(int unsigned lvl, ovr_t o);
      if (may_push(lvl))
        push(lvl, o, 1'b0);
      else if (iso_ovf == 0 && emb_ovf < CNT_MAX)
        emb_ovf++;
    endfunction

    function logic [CLS_W-1:0] forced(ovr_t o, logic [CLS_W-1:0] cls);
      if (o == OVR_LTR) return CL_L;
      if (o == OVR_RTL) return CL_R;
      return cls;
    endfunction

    function level_result_t resolve(logic [7:0] d);
      logic [CLS_W-1:0] cls;
      int unsigned      cur;
      int unsigned      lvl;
      ovr_t             co;
      bit               rtl;
      level_result_t    r;
      cls = d[4:0];
      if (d[6]) restart();
      cur = lvl_q[depth-1];
      co = ovr_q[depth-1];
      r.level = '0;
      r.assigned = 1'b1;
      r.cls = cls;
      case (cls)
        CL_RLE, CL_RLO: begin
          open_embedding((cur + 1) | 1, cls == CL_RLO ? OVR_RTL : OVR_NONE);
          r.assigned = 1'b0;
        end
        CL_LRE, CL_LRO: begin
          open_embedding((cur + 2) & 32'hFFFF_FFFE, cls == CL_LRO ? OVR_LTR : OVR_NONE);
          r.assigned = 1'b0;
        end
        CL_LRI, CL_RLI, CL_FSI: begin
          rtl = cls == CL_RLI || (cls == CL_FSI && d[5]);
          r.level = cur[LVL_W-1:0];
          if (co != OVR_NONE)
            r.cls = forced(co, cls);
          else if (cls == CL_FSI)
            r.cls = rtl ? CL_RLI : CL_LRI;
          lvl = rtl ? ((cur + 1) | 1) : ((cur + 2) & 32'hFFFF_FFFE);
          if (may_push(lvl)) begin
            if (open_iso < 127) open_iso++;
            push(lvl, OVR_NONE, 1'b1);
          end else if (iso_ovf < CNT_MAX) begin
            iso_ovf++;
          end
        end
        CL_PDI: begin
          if (iso_ovf != 0) begin
            iso_ovf--;
          end else if (open_iso != 0) begin
            // unwind to the nearest isolate entry and drop it as well
            emb_ovf = 0;
            while (depth > 1 && !iso_q[depth-1]) depth--;
            if (depth > 1) depth--;
            open_iso--;
          end
          r.level = lvl_q[depth-1];
          r.cls = forced(ovr_q[depth-1], cls);
        end
        CL_PDF: begin
          if (iso_ovf == 0) begin
            if (emb_ovf != 0)
              emb_ovf--;
            else if (depth > 1 && !iso_q[depth-1])
              depth--;
          end
          r.assigned = 1'b0;
        end
        CL_B: begin
          r.level = LVL_W'(base);
          restart();
        end
        CL_BN: begin
          r.assigned = 1'b0;
        end
        default: begin
          r.level = cur[LVL_W-1:0];
          r.cls = forced(co, cls);
        end
      endcase
      return r;
    endfunction

    function void note_input(logic [7:0] d);
      due_results.push_back(resolve(d));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [15:0] d);
      level_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result item %h", d));
        return;
      end
      want = due_results.pop_front();
      if (d[6:0] !== want.level)
        report($sformatf("embed_level %0d, want %0d", d[6:0], want.level));
      if (d[7] !== want.assigned)
        report($sformatf("level_assigned %0b, want %0b", d[7], want.assigned));
      if (d[12:8] !== want.cls)
        report($sformatf("out_class %0d, want %0d", d[12:8], want.cls));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // char_class[4:0], fsi_is_rtl[5], text_start[6], zero[7]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // embed_level[6:0], level_assigned[7], out_class[12:8], zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_data;   // base_level

  level_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              cycles = 0;
  int              sb_checked = 0;
  logic [CLS_W-1:0] openers[7] = '{CL_LRE, CL_LRO, CL_RLE, CL_RLO, CL_LRI, CL_RLI, CL_FSI};

  bidi_explicit_level_resolver u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit coin();
    return 1'($urandom_range(1));
  endfunction

  task automatic send_item(input logic [CLS_W-1:0] cls, input bit fsi, input bit ts);
    while (!quiet && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, ts, fsi, cls};
    do @(posedge clk); while (!in_tready);
    sb.note_input({1'b0, ts, fsi, cls});
  endtask

  task automatic write_base(input bit b);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= b;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.load_base(b);
  endtask

  // Mostly balanced nesting with random text, plus deep bursts, stray closers and junk.
  task automatic run_text(input int n);
    logic [CLS_W-1:0] nest[$];
    logic [CLS_W-1:0] cls;
    logic [CLS_W-1:0] o;
    int               sent;
    int               r;
    bit               ts;
    sent = 0;
    while (sent < n) begin
      r  = $urandom_range(99);
      ts = ($urandom_range(49) == 0);
      if (ts) nest.delete();
      if (nest.size() != 0 && r < 25) begin
        o = nest.pop_back();
        cls = (o == CL_LRI || o == CL_RLI || o == CL_FSI) ? CL_PDI : CL_PDF;
      end else if (r < 45 || nest.size() > 140) begin
        cls = openers[$urandom_range(6)];
        nest.push_back(cls);
      end else if (r < 46) begin
        repeat ($urandom_range(70, 55)) begin
          o = openers[$urandom_range(6)];
          nest.push_back(o);
          send_item(o, coin(), 1'b0);
          sent++;
        end
        continue;
      end else if (r < 50) begin
        case ($urandom_range(3))
          0: cls = CL_PDF;
          1: cls = CL_PDI;
          2: cls = CL_BN;
          default: cls = CLS_W'($urandom_range(31, CL_PDI + 1));
        endcase
      end else if (r < 52) begin
        cls = CL_B;
        nest.delete();
      end else begin
        cls = CLS_W'($urandom_range(CL_LRE - 1, CL_L));
        if (cls == CL_B) nest.delete();
      end
      send_item(cls, coin(), ts);
      sent++;
    end
  endtask

  // Climb to the deepest level, run both overflow counters up, step them partly back down, then clear them with a B.
  task automatic overflow_stack();
    send_item(CL_LRE, coin(), 1'b1);
    repeat (61) send_item(CL_LRE, coin(), 1'b0);
    repeat (30) send_item(openers[$urandom_range(3)], coin(), 1'b0);
    repeat (3) send_item(CL_PDF, coin(), 1'b0);
    repeat (5) send_item(openers[$urandom_range(3)], coin(), 1'b0);
    repeat (30) send_item(openers[$urandom_range(6, 4)], coin(), 1'b0);
    repeat (4) begin
      send_item(CL_PDI, coin(), 1'b0);
      send_item(CL_PDF, coin(), 1'b0);
      send_item(CLS_W'($urandom_range(CL_LRE - 1, CL_L)), coin(), 1'b0);
    end
    send_item(CL_B, 1'b0, 1'b0);
  endtask

  // Result side: random back-pressure, with one long hold-off to fill the block.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sb.due_results.size() > 0 && cycles > 0 && sb_checked >= PRESSURE_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (120) @(posedge clk);
      end
      out_tready <= quiet || $urandom_range(99) >= 25;
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        sb_checked++;
      end
    end
  end

  initial begin : stimulus
    int waited;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every embedding and override opener first, so the plain classes run under a right-to-left override
    send_item(CL_LRE, 1'b0, 1'b0);
    send_item(CL_LRO, 1'b0, 1'b0);
    send_item(CL_RLE, 1'b0, 1'b0);
    send_item(CL_RLO, 1'b0, 1'b0);
    for (int c = CL_L; c < CL_LRE; c++)
      if (c != CL_B) send_item(CLS_W'(c), 1'b0, 1'b0);
    send_item(CL_PDF, 1'b0, 1'b0);
    send_item(CL_LRI, 1'b0, 1'b0);
    send_item(CL_RLI, 1'b0, 1'b0);
    send_item(CL_FSI, 1'b0, 1'b0);
    send_item(CL_FSI, 1'b1, 1'b0);
    send_item(CL_PDI, 1'b0, 1'b0);
    send_item(CLS_W'(CL_PDI + 1), 1'b1, 1'b0);
    send_item(5'd31, 1'b1, 1'b1);
    send_item(CL_B, 1'b0, 1'b0);

    write_base(1'b1);
    quiet = 1'b1;
    run_text(140);
    quiet = 1'b0;
    write_base(1'b0);
    run_text(140);
    write_base(1'b1);
    run_text(140);
    overflow_stack();
    write_base(1'b0);
    run_text(40);
    in_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
